// File: sv/sm4_pkg.sv
`default_nettype none

package sm4_pkg;

  localparam int unsigned ROUNDS_DEF = 32;
  localparam int unsigned WORD_W     = 32;
  localparam int unsigned BLOCK_W    = 128;
  localparam int unsigned KEY_REG_W  = 64;
  localparam int unsigned CFG_IDX_W  = 2;

  typedef logic [WORD_W-1:0] word_t;

  // configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_KEY_HIGH = 2'd0,
    REG_KEY_LOW  = 2'd1
  } cfg_reg_t;

  // selects the linear layer of the shared round unit
  typedef enum logic {
    MODE_CIPHER = 1'b0,
    MODE_KEY    = 1'b1
  } t_mode_t;

  typedef struct packed {
    t_mode_t mode;
  } unit_ctrl_t;

  localparam logic [7:0] SBOX [0:255] = '{
    8'hD6,8'h90,8'hE9,8'hFE,8'hCC,8'hE1,8'h3D,8'hB7,8'h16,8'hB6,8'h14,8'hC2,8'h28,8'hFB,8'h2C,8'h05,
    8'h2B,8'h67,8'h9A,8'h76,8'h2A,8'hBE,8'h04,8'hC3,8'hAA,8'h44,8'h13,8'h26,8'h49,8'h86,8'h06,8'h99,
    8'h9C,8'h42,8'h50,8'hF4,8'h91,8'hEF,8'h98,8'h7A,8'h33,8'h54,8'h0B,8'h43,8'hED,8'hCF,8'hAC,8'h62,
    8'hE4,8'hB3,8'h1C,8'hA9,8'hC9,8'h08,8'hE8,8'h95,8'h80,8'hDF,8'h94,8'hFA,8'h75,8'h8F,8'h3F,8'hA6,
    8'h47,8'h07,8'hA7,8'hFC,8'hF3,8'h73,8'h17,8'hBA,8'h83,8'h59,8'h3C,8'h19,8'hE6,8'h85,8'h4F,8'hA8,
    8'h68,8'h6B,8'h81,8'hB2,8'h71,8'h64,8'hDA,8'h8B,8'hF8,8'hEB,8'h0F,8'h4B,8'h70,8'h56,8'h9D,8'h35,
    8'h1E,8'h24,8'h0E,8'h5E,8'h63,8'h58,8'hD1,8'hA2,8'h25,8'h22,8'h7C,8'h3B,8'h01,8'h21,8'h78,8'h87,
    8'hD4,8'h00,8'h46,8'h57,8'h9F,8'hD3,8'h27,8'h52,8'h4C,8'h36,8'h02,8'hE7,8'hA0,8'hC4,8'hC8,8'h9E,
    8'hEA,8'hBF,8'h8A,8'hD2,8'h40,8'hC7,8'h38,8'hB5,8'hA3,8'hF7,8'hF2,8'hCE,8'hF9,8'h61,8'h15,8'hA1,
    8'hE0,8'hAE,8'h5D,8'hA4,8'h9B,8'h34,8'h1A,8'h55,8'hAD,8'h93,8'h32,8'h30,8'hF5,8'h8C,8'hB1,8'hE3,
    8'h1D,8'hF6,8'hE2,8'h2E,8'h82,8'h66,8'hCA,8'h60,8'hC0,8'h29,8'h23,8'hAB,8'h0D,8'h53,8'h4E,8'h6F,
    8'hD5,8'hDB,8'h37,8'h45,8'hDE,8'hFD,8'h8E,8'h2F,8'h03,8'hFF,8'h6A,8'h72,8'h6D,8'h6C,8'h5B,8'h51,
    8'h8D,8'h1B,8'hAF,8'h92,8'hBB,8'hDD,8'hBC,8'h7F,8'h11,8'hD9,8'h5C,8'h41,8'h1F,8'h10,8'h5A,8'hD8,
    8'h0A,8'hC1,8'h31,8'h88,8'hA5,8'hCD,8'h7B,8'hBD,8'h2D,8'h74,8'hD0,8'h12,8'hB8,8'hE5,8'hB4,8'hB0,
    8'h89,8'h69,8'h97,8'h4A,8'h0C,8'h96,8'h77,8'h7E,8'h65,8'hB9,8'hF1,8'h09,8'hC5,8'h6E,8'hC6,8'h84,
    8'h18,8'hF0,8'h7D,8'hEC,8'h3A,8'hDC,8'h4D,8'h20,8'h79,8'hEE,8'h5F,8'h3E,8'hD7,8'hCB,8'h39,8'h48
  };

  localparam word_t FK [0:3] = '{
    32'hA3B1BAC6, 32'h56AA3350, 32'h677D9197, 32'hB27022DC
  };

  localparam word_t CK [0:31] = '{
    32'h00070E15, 32'h1C232A31, 32'h383F464D, 32'h545B6269,
    32'h70777E85, 32'h8C939AA1, 32'hA8AFB6BD, 32'hC4CBD2D9,
    32'hE0E7EEF5, 32'hFC030A11, 32'h181F262D, 32'h343B4249,
    32'h50575E65, 32'h6C737A81, 32'h888F969D, 32'hA4ABB2B9,
    32'hC0C7CED5, 32'hDCE3EAF1, 32'hF8FF060D, 32'h141B2229,
    32'h30373E45, 32'h4C535A61, 32'h686F767D, 32'h848B9299,
    32'hA0A7AEB5, 32'hBCC3CAD1, 32'hD8DFE6ED, 32'hF4FB0209,
    32'h10171E25, 32'h2C333A41, 32'h484F565D, 32'h646B7279
  };

endpackage

`default_nettype wire

// File: sv/sm4_round_unit.sv
`default_nettype none

// Shared T / T' unit: xor of three words and a key word, byte S-box, then
// the cipher or key-schedule linear layer.
module sm4_round_unit (
  input  wire  sm4_pkg::word_t      x1,
  input  wire  sm4_pkg::word_t      x2,
  input  wire  sm4_pkg::word_t      x3,
  input  wire  sm4_pkg::word_t      k,
  input  wire  sm4_pkg::unit_ctrl_t ctrl,
  output logic [31:0]               t
);
  import sm4_pkg::*;

  function automatic word_t rotl(input word_t v, input int unsigned n);
    return (v << n) | (v >> (WORD_W - n));
  endfunction

  word_t v;
  word_t b;

  always_comb begin
    v = x1 ^ x2 ^ x3 ^ k;
    b = {SBOX[v[31:24]], SBOX[v[23:16]], SBOX[v[15:8]], SBOX[v[7:0]]};
    if (ctrl.mode == MODE_KEY) begin
      t = b ^ rotl(b, 13) ^ rotl(b, 23);
    end else begin
      t = b ^ rotl(b, 2) ^ rotl(b, 10) ^ rotl(b, 18) ^ rotl(b, 24);
    end
  end

endmodule

`default_nettype wire

// File: sv/sm4_block_cipher.sv
`default_nettype none

// SM4 block cipher, ECB, one round per clock (last round stalls on a full output), one shared round unit.
//
// Channels:
//   s_*  : input beat. s_tdata = {block_low, block_high}, s_tuser = cmd
//          (0 encrypt, 1 decrypt). Taken when s_tvalid && s_tready.
//   m_*  : result beat. m_tdata = {result_low, result_high}.
//   cfg_*: key write port. Index 0 = key_high, index 1 = key_low. Any key
//          write restarts round-key expansion; other indexes are dropped.
// Operation:
//   Key expansion is a load step followed by 32 key rounds; s_tready stays
//   low meanwhile, and also in any cycle with a key write.
//   A block is accepted in the idle state and runs 32 rounds: m_tvalid is
//   registered as the last round ends, and the next block can be taken in
//   the idle state after that, so the shared round unit holds one block at a time.
// Reset: key registers clear to zero and the all-zero key is expanded before
//   the first block is taken.
// Backpressure: the output register holds the result while m_tready is low;
//   the next block may be accepted meanwhile, and its last round waits until
//   the output register is free.
module sm4_block_cipher #(
  parameter int unsigned ROUNDS = sm4_pkg::ROUNDS_DEF
) (
  input  wire                                   clk,
  input  wire                                   rst,
  input  wire                                   s_tvalid,
  output logic                                  s_tready,
  // [63:0] block_high, [127:64] block_low
  input  wire  [sm4_pkg::BLOCK_W-1:0]           s_tdata,
  // [0] cmd
  input  wire                                   s_tuser,
  output logic                                  m_tvalid,
  input  wire                                   m_tready,
  // [63:0] result_high, [127:64] result_low
  output logic [sm4_pkg::BLOCK_W-1:0]           m_tdata,
  input  wire                                   cfg_we,
  input  wire  [sm4_pkg::CFG_IDX_W-1:0]         cfg_index,
  input  wire  [sm4_pkg::KEY_REG_W-1:0]         cfg_data
);
  import sm4_pkg::*;

  localparam int unsigned CNT_W = $clog2(ROUNDS);
  localparam logic [CNT_W-1:0] LAST = CNT_W'(ROUNDS - 1);

  typedef enum logic [4:0] {
    ST_KINIT = 5'b00001,
    ST_KEY   = 5'b00010,
    ST_IDLE  = 5'b00100,
    ST_RUN   = 5'b01000,
    ST_HOLD  = 5'b10000
  } state_t;

  state_t                 state;
  state_t                 state_next;
  logic [CNT_W-1:0]       cnt;
  logic                   dec;
  logic [KEY_REG_W-1:0]   key_high;
  logic [KEY_REG_W-1:0]   key_low;
  word_t                  x0, x1, x2, x3;
  word_t                  rk [ROUNDS];

  logic                   key_write;
  logic                   out_free;
  logic                   last_rnd;
  logic                   accept;
  logic                   do_kinit;
  logic                   do_key;
  logic                   do_round;
  logic                   finish;
  logic [CNT_W-1:0]       rk_addr;
  word_t                  k_in;
  word_t                  t;
  word_t                  nx;
  unit_ctrl_t             uctrl;

  assign key_write = cfg_we && (cfg_index == REG_KEY_HIGH || cfg_index == REG_KEY_LOW);
  assign out_free  = !m_tvalid || m_tready;
  assign last_rnd  = (cnt == LAST);
  // a key write takes priority over a new block
  assign s_tready  = (state == ST_IDLE) && !key_write;
  assign accept    = s_tvalid && s_tready;

  assign do_kinit  = (state == ST_KINIT) && !key_write;
  assign do_key    = (state == ST_KEY) && !key_write;
  // last round waits for the output register
  assign do_round  = (state == ST_RUN) && !(last_rnd && !out_free);
  assign finish    = do_round && last_rnd;

  // decryption walks the round keys backwards
  assign rk_addr   = dec ? (LAST - cnt) : cnt;
  assign k_in      = (state == ST_KEY) ? CK[5'(cnt)] : rk[rk_addr];
  assign uctrl.mode = (state == ST_KEY) ? MODE_KEY : MODE_CIPHER;
  assign nx        = x0 ^ t;

  sm4_round_unit u_round (
    .x1   (x1),
    .x2   (x2),
    .x3   (x3),
    .k    (k_in),
    .ctrl (uctrl),
    .t    (t)
  );

  always_comb begin
    state_next = state;
    case (state)
      ST_KINIT: state_next = ST_KEY;
      ST_KEY:   if (last_rnd) begin
        state_next = ST_IDLE;
      end
      ST_IDLE:  if (accept) begin
        state_next = ST_RUN;
      end
      ST_RUN:   if (finish) begin
        state_next = ST_IDLE;
      end
      default:  state_next = ST_KINIT;
    endcase
    if (key_write) begin
      state_next = ST_KINIT;
    end
  end

  // control
  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_KINIT;
      cnt      <= '0;
      key_high <= '0;
      key_low  <= '0;
      m_tvalid <= 1'b0;
    end else begin
      state <= state_next;
      if (key_write) begin
        if (cfg_index == REG_KEY_HIGH) begin
          key_high <= cfg_data;
        end else begin
          key_low <= cfg_data;
        end
      end
      if (key_write || do_kinit || accept || finish || (do_key && last_rnd)) begin
        cnt <= '0;
      end else if (do_key || do_round) begin
        cnt <= cnt + 1'b1;
      end
      if (finish) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    if (do_kinit) begin
      x0 <= key_high[63:32] ^ FK[0];
      x1 <= key_high[31:0]  ^ FK[1];
      x2 <= key_low[63:32]  ^ FK[2];
      x3 <= key_low[31:0]   ^ FK[3];
    end else if (accept) begin
      x0  <= s_tdata[63:32];
      x1  <= s_tdata[31:0];
      x2  <= s_tdata[127:96];
      x3  <= s_tdata[95:64];
      dec <= s_tuser;
    end else if (do_key || do_round) begin
      x0 <= x1;
      x1 <= x2;
      x2 <= x3;
      x3 <= nx;
    end
    if (do_key) begin
      rk[cnt] <= nx;
    end
    if (finish) begin
      // reverse-order swap
      m_tdata <= {x2, x1, nx, x3};
    end
  end

  a_busy_key: assert property (@(posedge clk) disable iff (rst)
    (state == ST_KINIT || state == ST_KEY) |-> !s_tready)
    else $error("block accepted during key expansion");

  a_result_from_run: assert property (@(posedge clk) disable iff (rst)
    $rose(m_tvalid) |-> $past(state == ST_RUN))
    else $error("result raised outside a block run");

  a_idle_count: assert property (@(posedge clk) disable iff (rst)
    (state == ST_IDLE) |-> (cnt == '0))
    else $error("round counter not cleared in idle");

  a_accept_starts: assert property (@(posedge clk) disable iff (rst)
    (s_tvalid && s_tready && !key_write) |=> (state == ST_RUN && cnt == '0))
    else $error("accepted block did not start at round zero");

  a_key_restart: assert property (@(posedge clk) disable iff (rst)
    key_write |=> (state == ST_KINIT))
    else $error("key write did not restart expansion");

endmodule

`default_nettype wire

// File: verif/tb.sv
`timescale 1ns / 1ps

module tb;
  import sm4_pkg::*;

  // Run length and tail timing
  localparam int unsigned CYCLE_LIMIT  = 1_000_000;
  localparam int unsigned TAIL_CYCLES  = 100;   // longer than one block run, with margin
  localparam int unsigned RAND_PHASES  = 10;
  localparam int unsigned PHASE_BLOCKS = 120;   // 10 x 120 = ~1200 random blocks
  localparam int unsigned HOLD_CYCLES  = 300;   // long sink stall

  // Unused config slots; the block must drop writes to these
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_2 = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_3 = 2'd3;

  localparam logic DIR_ENC = 1'b0;
  localparam logic DIR_DEC = 1'b1;

  // Same packing as s_tdata / m_tdata: high half in the low 64 bits
  typedef struct packed {
    logic [63:0] lo;
    logic [63:0] hi;
  } blk_t;

  // Own copy of the SM4 S-box
  localparam logic [7:0] SBOX_LUT [256] = '{
    8'hD6,8'h90,8'hE9,8'hFE,8'hCC,8'hE1,8'h3D,8'hB7,8'h16,8'hB6,8'h14,8'hC2,8'h28,8'hFB,8'h2C,8'h05,
    8'h2B,8'h67,8'h9A,8'h76,8'h2A,8'hBE,8'h04,8'hC3,8'hAA,8'h44,8'h13,8'h26,8'h49,8'h86,8'h06,8'h99,
    8'h9C,8'h42,8'h50,8'hF4,8'h91,8'hEF,8'h98,8'h7A,8'h33,8'h54,8'h0B,8'h43,8'hED,8'hCF,8'hAC,8'h62,
    8'hE4,8'hB3,8'h1C,8'hA9,8'hC9,8'h08,8'hE8,8'h95,8'h80,8'hDF,8'h94,8'hFA,8'h75,8'h8F,8'h3F,8'hA6,
    8'h47,8'h07,8'hA7,8'hFC,8'hF3,8'h73,8'h17,8'hBA,8'h83,8'h59,8'h3C,8'h19,8'hE6,8'h85,8'h4F,8'hA8,
    8'h68,8'h6B,8'h81,8'hB2,8'h71,8'h64,8'hDA,8'h8B,8'hF8,8'hEB,8'h0F,8'h4B,8'h70,8'h56,8'h9D,8'h35,
    8'h1E,8'h24,8'h0E,8'h5E,8'h63,8'h58,8'hD1,8'hA2,8'h25,8'h22,8'h7C,8'h3B,8'h01,8'h21,8'h78,8'h87,
    8'hD4,8'h00,8'h46,8'h57,8'h9F,8'hD3,8'h27,8'h52,8'h4C,8'h36,8'h02,8'hE7,8'hA0,8'hC4,8'hC8,8'h9E,
    8'hEA,8'hBF,8'h8A,8'hD2,8'h40,8'hC7,8'h38,8'hB5,8'hA3,8'hF7,8'hF2,8'hCE,8'hF9,8'h61,8'h15,8'hA1,
    8'hE0,8'hAE,8'h5D,8'hA4,8'h9B,8'h34,8'h1A,8'h55,8'hAD,8'h93,8'h32,8'h30,8'hF5,8'h8C,8'hB1,8'hE3,
    8'h1D,8'hF6,8'hE2,8'h2E,8'h82,8'h66,8'hCA,8'h60,8'hC0,8'h29,8'h23,8'hAB,8'h0D,8'h53,8'h4E,8'h6F,
    8'hD5,8'hDB,8'h37,8'h45,8'hDE,8'hFD,8'h8E,8'h2F,8'h03,8'hFF,8'h6A,8'h72,8'h6D,8'h6C,8'h5B,8'h51,
    8'h8D,8'h1B,8'hAF,8'h92,8'hBB,8'hDD,8'hBC,8'h7F,8'h11,8'hD9,8'h5C,8'h41,8'h1F,8'h10,8'h5A,8'hD8,
    8'h0A,8'hC1,8'h31,8'h88,8'hA5,8'hCD,8'h7B,8'hBD,8'h2D,8'h74,8'hD0,8'h12,8'hB8,8'hE5,8'hB4,8'hB0,
    8'h89,8'h69,8'h97,8'h4A,8'h0C,8'h96,8'h77,8'h7E,8'h65,8'hB9,8'hF1,8'h09,8'hC5,8'h6E,8'hC6,8'h84,
    8'h18,8'hF0,8'h7D,8'hEC,8'h3A,8'hDC,8'h4D,8'h20,8'h79,8'hEE,8'h5F,8'h3E,8'hD7,8'hCB,8'h39,8'h48
  };

  localparam logic [31:0] FK_WORDS [4] = '{
    32'hA3B1BAC6, 32'h56AA3350, 32'h677D9197, 32'hB27022DC
  };

  logic                  clk;
  logic                  rst;
  logic                  s_tvalid;
  logic                  s_tready;
  logic [BLOCK_W-1:0]    s_tdata;   // [63:0] block_high, [127:64] block_low
  logic                  s_tuser;   // [0] cmd
  logic                  m_tvalid;
  logic                  m_tready;
  logic [BLOCK_W-1:0]    m_tdata;   // [63:0] result_high, [127:64] result_low
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [KEY_REG_W-1:0]  cfg_data;

  // Shadow key state: registers plus expanded schedule
  logic [63:0] key_hi_q;
  logic [63:0] key_lo_q;
  logic [31:0] round_keys [32];

  blk_t        cipher_expected_q [$];
  int unsigned fail_cnt;
  int unsigned cycle_cnt;

  // Random idling controls, and a one-shot long sink stall request
  bit          src_idle_en;
  bit          snk_idle_en;
  int unsigned sink_hold;

  sm4_block_cipher uut (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // ---------------------------------------------------------------------------
  // SM4 math
  // ---------------------------------------------------------------------------

  function automatic logic [31:0] rotl(input logic [31:0] v, input int n);
    return (v << n) | (v >> (32 - n));
  endfunction

  // nonlinear byte substitution (tau)
  function automatic logic [31:0] tau(input logic [31:0] v);
    return {SBOX_LUT[v[31:24]], SBOX_LUT[v[23:16]], SBOX_LUT[v[15:8]], SBOX_LUT[v[7:0]]};
  endfunction

  // CK byte j of word i is (4i+j)*7 mod 256
  function automatic logic [31:0] ck_word(input int i);
    logic [7:0] b0, b1, b2, b3;
    b0 = 8'((4 * i) * 7);
    b1 = 8'((4 * i + 1) * 7);
    b2 = 8'((4 * i + 2) * 7);
    b3 = 8'((4 * i + 3) * 7);
    return {b0, b1, b2, b3};
  endfunction

  function automatic void expand_round_keys();
    logic [31:0] w [4];
    logic [31:0] b, nk;
    w[0] = key_hi_q[63:32] ^ FK_WORDS[0];
    w[1] = key_hi_q[31:0]  ^ FK_WORDS[1];
    w[2] = key_lo_q[63:32] ^ FK_WORDS[2];
    w[3] = key_lo_q[31:0]  ^ FK_WORDS[3];
    for (int i = 0; i < 32; i++) begin
      b  = tau(w[1] ^ w[2] ^ w[3] ^ ck_word(i));
      nk = w[0] ^ b ^ rotl(b, 13) ^ rotl(b, 23);
      round_keys[i] = nk;
      w[0] = w[1];
      w[1] = w[2];
      w[2] = w[3];
      w[3] = nk;
    end
  endfunction

  // One block through 32 rounds with the current schedule; decrypt reverses it
  function automatic blk_t sm4_crypt(input logic dec, input logic [63:0] hi,
                                     input logic [63:0] lo);
    logic [31:0] x [4];
    logic [31:0] rk, b, nx;
    blk_t r;
    x[0] = hi[63:32];
    x[1] = hi[31:0];
    x[2] = lo[63:32];
    x[3] = lo[31:0];
    for (int i = 0; i < 32; i++) begin
      rk = dec ? round_keys[31 - i] : round_keys[i];
      b  = tau(x[1] ^ x[2] ^ x[3] ^ rk);
      nx = x[0] ^ b ^ rotl(b, 2) ^ rotl(b, 10) ^ rotl(b, 18) ^ rotl(b, 24);
      x[0] = x[1];
      x[1] = x[2];
      x[2] = x[3];
      x[3] = nx;
    end
    // final reverse-order swap
    r.hi = {x[3], x[2]};
    r.lo = {x[1], x[0]};
    return r;
  endfunction

  // ---------------------------------------------------------------------------
  // Stimulus primitives
  // ---------------------------------------------------------------------------

  // Key write; only legal while the core is idle. Shadow state follows the
  // same rules as the block: unused indexes change nothing.
  task automatic write_key_reg(input logic [CFG_IDX_W-1:0] idx, input logic [63:0] val);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    if (idx == REG_KEY_HIGH) begin
      key_hi_q = val;
      expand_round_keys();
    end else if (idx == REG_KEY_LOW) begin
      key_lo_q = val;
      expand_round_keys();
    end
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  // Offer one beat and hold it until taken; the expectation is queued at the
  // accepting edge, with the schedule in force at that moment.
  task automatic send_block(input logic dec, input logic [63:0] hi, input logic [63:0] lo);
    @(negedge clk);
    s_tvalid <= 1'b1;
    s_tuser  <= dec;
    s_tdata  <= {lo, hi};
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    cipher_expected_q.push_back(sm4_crypt(dec, hi, lo));
  endtask

  // Drop tvalid to idle the source; n sets the length of the gap
  task automatic pause_input(input int unsigned n);
    @(negedge clk);
    s_tvalid <= 1'b0;
    repeat (n - 1) @(negedge clk);
  endtask

  task automatic maybe_gap();
    if (src_idle_en && $urandom_range(0, 3) == 0) pause_input($urandom_range(1, 15));
  endtask

  // Stop offering and wait for every outstanding result
  task automatic drain_results();
    @(negedge clk);
    s_tvalid <= 1'b0;
    while (cipher_expected_q.size() != 0) @(posedge clk);
    @(negedge clk);
  endtask

  function automatic logic [63:0] rand64();
    return {$urandom, $urandom};
  endfunction

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // Schedule from reset must be that of the all-zero key
  task automatic test_reset_key();
    send_block(DIR_ENC, '0, '0);
    send_block(DIR_ENC, '1, '1);
    send_block(DIR_DEC, '0, '0);
    send_block(DIR_DEC, '1, '1);
    drain_results();
  endtask

  // Standard published vector; also guards the local math
  task automatic test_known_answer();
    blk_t pt, ct;
    pt = '{lo: 64'hFEDCBA9876543210, hi: 64'h0123456789ABCDEF};
    ct = '{lo: 64'h86B3E94F536E4246, hi: 64'h681EDF34D206965E};
    write_key_reg(REG_KEY_HIGH, pt.hi);
    write_key_reg(REG_KEY_LOW, pt.lo);
    if (sm4_crypt(DIR_ENC, pt.hi, pt.lo) != ct) begin
      $error("local SM4 math disagrees with the standard vector");
      fail_cnt++;
    end
    send_block(DIR_ENC, pt.hi, pt.lo);
    send_block(DIR_DEC, ct.hi, ct.lo);
    drain_results();
  endtask

  // All-ones key, corner data patterns in both directions
  task automatic test_block_extremes();
    write_key_reg(REG_KEY_HIGH, '1);
    write_key_reg(REG_KEY_LOW, '1);
    send_block(DIR_ENC, '0, '0);
    send_block(DIR_DEC, '1, '1);
    send_block(DIR_ENC, {32{2'b10}}, {32{2'b01}});
    send_block(DIR_DEC, {32{2'b01}}, {32{2'b10}});
    send_block(DIR_ENC, 64'h8000_0000_0000_0000, 64'h0000_0000_0000_0001);
    send_block(DIR_DEC, 64'h0000_0000_0000_0001, 64'h8000_0000_0000_0000);
    drain_results();
  endtask

  // Writes to unused indexes must leave the schedule alone
  task automatic test_ignored_index();
    write_key_reg(REG_SPARE_2, rand64());
    write_key_reg(REG_SPARE_3, '1);
    send_block(DIR_ENC, rand64(), rand64());
    send_block(DIR_DEC, rand64(), rand64());
    drain_results();
  endtask

  // Blocks between the two halves of a key change see the half-new key
  task automatic test_half_key();
    write_key_reg(REG_KEY_HIGH, rand64());
    send_block(DIR_ENC, rand64(), rand64());
    send_block(DIR_DEC, rand64(), rand64());
    drain_results();
    write_key_reg(REG_KEY_LOW, rand64());
    send_block(DIR_ENC, rand64(), rand64());
    send_block(DIR_DEC, rand64(), rand64());
    drain_results();
  endtask

  // Sink stalls long while the source keeps offering: output register fills,
  // last round waits, input stalls.
  task automatic test_backpressure();
    sink_hold = HOLD_CYCLES;
    for (int i = 0; i < 10; i++) send_block(logic'($urandom_range(0, 1)), rand64(), rand64());
    drain_results();
  endtask

  // Random phases; each starts from idle with a fresh key setting
  task automatic test_random_traffic();
    blk_t        last_ct;
    logic [63:0] hi, lo;
    for (int unsigned ph = 0; ph < RAND_PHASES; ph++) begin
      // no idling at all in the closing phase
      if (ph == RAND_PHASES - 1) begin
        src_idle_en = 1'b0;
        snk_idle_en = 1'b0;
      end
      drain_results();
      case ($urandom_range(0, 4))
        0: begin
          write_key_reg(REG_KEY_HIGH, rand64());
          write_key_reg(REG_KEY_LOW, rand64());
        end
        1: write_key_reg(REG_KEY_HIGH, rand64());
        2: write_key_reg(REG_KEY_LOW, rand64());
        3: begin
          write_key_reg(REG_KEY_HIGH, $urandom_range(0, 1) ? '1 : '0);
          write_key_reg(REG_KEY_LOW, $urandom_range(0, 1) ? '1 : '0);
        end
        default: begin
          write_key_reg($urandom_range(0, 1) ? REG_SPARE_2 : REG_SPARE_3, rand64());
          write_key_reg(REG_KEY_LOW, rand64());
        end
      endcase
      last_ct = sm4_crypt(DIR_ENC, rand64(), rand64());
      for (int unsigned n = 0; n < PHASE_BLOCKS; n++) begin
        hi = rand64();
        lo = rand64();
        case ($urandom_range(0, 3))
          0, 1: begin
            send_block(DIR_ENC, hi, lo);
            last_ct = sm4_crypt(DIR_ENC, hi, lo);
          end
          2: send_block(DIR_DEC, hi, lo);
          // round trip: decrypt the latest ciphertext under the same key
          default: send_block(DIR_DEC, last_ct.hi, last_ct.lo);
        endcase
        maybe_gap();
      end
    end
    drain_results();
  endtask

  // ---------------------------------------------------------------------------
  // Sink ready: random bursts, with a long hold when a test asks for it
  // ---------------------------------------------------------------------------
  initial begin : sink_ready
    int unsigned n;
    m_tready = 1'b0;
    @(negedge clk);
    forever begin
      if (sink_hold != 0) begin
        n = sink_hold;
        sink_hold = 0;
        m_tready <= 1'b0;
        repeat (n) @(negedge clk);
      end else if (snk_idle_en && $urandom_range(0, 3) == 0) begin
        m_tready <= 1'b0;
        repeat ($urandom_range(1, 15)) @(negedge clk);
      end else begin
        m_tready <= 1'b1;
        repeat ($urandom_range(1, 20)) @(negedge clk);
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Result checker: each output beat against the oldest expectation
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    blk_t got, exp_blk;
    if (!rst && m_tvalid && m_tready) begin
      got = m_tdata;
      if (cipher_expected_q.size() == 0) begin
        $error("result beat with nothing expected: result_high=%h result_low=%h",
               got.hi, got.lo);
        fail_cnt++;
      end else begin
        exp_blk = cipher_expected_q.pop_front();
        if (got.hi !== exp_blk.hi) begin
          $error("result_high mismatch: expected %h, actual %h", exp_blk.hi, got.hi);
          fail_cnt++;
        end
        if (got.lo !== exp_blk.lo) begin
          $error("result_low mismatch: expected %h, actual %h", exp_blk.lo, got.lo);
          fail_cnt++;
        end
      end
    end
  end

  // Watchdog
  always @(posedge clk) begin
    cycle_cnt++;
    if (cycle_cnt == CYCLE_LIMIT) begin
      $display("status: fail");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Sequence
  // ---------------------------------------------------------------------------
  initial begin
    rst         = 1'b1;
    s_tvalid    = 1'b0;
    s_tdata     = '0;
    s_tuser     = 1'b0;
    cfg_we      = 1'b0;
    cfg_index   = REG_KEY_HIGH;
    cfg_data    = '0;
    fail_cnt    = 0;
    cycle_cnt   = 0;
    sink_hold   = 0;
    src_idle_en = 1'b1;
    snk_idle_en = 1'b1;
    key_hi_q    = '0;
    key_lo_q    = '0;
    expand_round_keys();

    repeat (6) @(negedge clk);
    rst <= 1'b0;

    test_reset_key();
    test_known_answer();
    test_block_extremes();
    test_ignored_index();
    test_half_key();
    test_backpressure();
    test_random_traffic();

    // let any stray beat show up before the verdict
    repeat (TAIL_CYCLES) @(posedge clk);
    if (fail_cnt == 0 && cipher_expected_q.size() == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule

// File: filelist.f
sv/sm4_pkg.sv
sv/sm4_round_unit.sv
sv/sm4_block_cipher.sv
verif/tb.sv
